@@ sv/s1a_pkg.sv @@
package s1a_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CharW = 7;
  localparam int unsigned IdxW  = 6;

  localparam logic [ByteW-1:0] CodePrefix  = 8'hE0;
  localparam logic [ByteW-1:0] CodeCtrl    = 8'h1D;
  localparam logic [ByteW-1:0] CodeLShift  = 8'h2A;
  localparam logic [ByteW-1:0] CodeRShift  = 8'h36;
  localparam logic [ByteW-1:0] CodeAlt     = 8'h38;
  localparam logic [ByteW-1:0] CodeCaps    = 8'h3A;
  localparam logic [ByteW-1:0] CodeLastKey = 8'h3A;

  typedef logic [CharW-1:0] char_t;

  typedef struct packed {
    char_t lower;
    char_t upper;
  } key_pair_t;

  function automatic key_pair_t key_lookup(input logic [IdxW-1:0] idx);
    key_pair_t p;
    unique case (idx)
      6'h01: p = '{7'h1B, 7'h1B};
      6'h02: p = '{7'h31, 7'h21};
      6'h03: p = '{7'h32, 7'h40};
      6'h04: p = '{7'h33, 7'h23};
      6'h05: p = '{7'h34, 7'h24};
      6'h06: p = '{7'h35, 7'h25};
      6'h07: p = '{7'h36, 7'h5E};
      6'h08: p = '{7'h37, 7'h26};
      6'h09: p = '{7'h38, 7'h2A};
      6'h0A: p = '{7'h39, 7'h28};
      6'h0B: p = '{7'h30, 7'h29};
      6'h0C: p = '{7'h2D, 7'h5F};
      6'h0D: p = '{7'h3D, 7'h2B};
      6'h0E: p = '{7'h08, 7'h08};
      6'h0F: p = '{7'h09, 7'h09};
      6'h10: p = '{7'h71, 7'h51};
      6'h11: p = '{7'h77, 7'h57};
      6'h12: p = '{7'h65, 7'h45};
      6'h13: p = '{7'h72, 7'h52};
      6'h14: p = '{7'h74, 7'h54};
      6'h15: p = '{7'h79, 7'h59};
      6'h16: p = '{7'h75, 7'h55};
      6'h17: p = '{7'h69, 7'h49};
      6'h18: p = '{7'h6F, 7'h4F};
      6'h19: p = '{7'h70, 7'h50};
      6'h1A: p = '{7'h5B, 7'h7B};
      6'h1B: p = '{7'h5D, 7'h7D};
      6'h1C: p = '{7'h0D, 7'h0D};
      6'h1E: p = '{7'h61, 7'h41};
      6'h1F: p = '{7'h73, 7'h53};
      6'h20: p = '{7'h64, 7'h44};
      6'h21: p = '{7'h66, 7'h46};
      6'h22: p = '{7'h67, 7'h47};
      6'h23: p = '{7'h68, 7'h48};
      6'h24: p = '{7'h6A, 7'h4A};
      6'h25: p = '{7'h6B, 7'h4B};
      6'h26: p = '{7'h6C, 7'h4C};
      6'h27: p = '{7'h3B, 7'h3A};
      6'h28: p = '{7'h27, 7'h22};
      6'h29: p = '{7'h60, 7'h7E};
      6'h2B: p = '{7'h5C, 7'h7C};
      6'h2C: p = '{7'h7A, 7'h5A};
      6'h2D: p = '{7'h78, 7'h58};
      6'h2E: p = '{7'h63, 7'h43};
      6'h2F: p = '{7'h76, 7'h56};
      6'h30: p = '{7'h62, 7'h42};
      6'h31: p = '{7'h6E, 7'h4E};
      6'h32: p = '{7'h6D, 7'h4D};
      6'h33: p = '{7'h2C, 7'h3C};
      6'h34: p = '{7'h2E, 7'h3E};
      6'h35: p = '{7'h2F, 7'h3F};
      6'h37: p = '{7'h2A, 7'h2A};
      6'h39: p = '{7'h20, 7'h20};
      default: p = '{7'h00, 7'h00};
    endcase
    return p;
  endfunction

  function automatic logic is_symbol_key(input logic [ByteW-1:0] code);
    return (code < 8'h0E) || (code == 8'h1A) || (code == 8'h1B) || (code == 8'h2B) ||
           ((code > 8'h26) && (code < 8'h2A)) || ((code > 8'h32) && (code < 8'h36));
  endfunction

endpackage

@@ sv/s1a_if.sv @@
interface s1a_in_if;
  logic                        valid;
  logic                        ready;
  logic [s1a_pkg::ByteW-1:0]   scan_byte;

  modport source (output valid, output scan_byte, input ready);
  modport sink   (input valid, input scan_byte, output ready);
endinterface

interface s1a_out_if;
  logic                        valid;
  logic                        ready;
  logic                        char_valid;
  logic [s1a_pkg::CharW-1:0]   ascii_char;
  logic                        unknown_key;
  logic                        ctrl_down;
  logic                        shift_down;
  logic                        alt_down;
  logic                        caps_on;

  modport source (output valid, output char_valid, output ascii_char, output unknown_key,
                  output ctrl_down, output shift_down, output alt_down, output caps_on,
                  input ready);
  modport sink   (input valid, input char_valid, input ascii_char, input unknown_key,
                  input ctrl_down, input shift_down, input alt_down, input caps_on,
                  output ready);
endinterface

@@ sv/scancode_set1_to_ascii.sv @@
// The result of an accepted scancode request is loaded into the output register.
// Throughput: one request per cycle; the output register takes a new result whenever
// it is empty or its current result is taken in the same cycle.
// Reset (synchronous, rst high): clears the prefix flag, the ctrl, shift, alt and
// caps-lock states, and the output valid flag.
module scancode_set1_to_ascii (
  input  logic       clk,
  input  logic       rst,
  s1a_in_if.sink     scan,
  s1a_out_if.source  result
);

  logic prefix_seen, prefix_seen_next;
  logic ctrl_held, ctrl_held_next;
  logic shift_held, shift_held_next;
  logic alt_held, alt_held_next;
  logic caps_lock_on, caps_lock_on_next;

  logic                 out_valid;
  logic                 out_char_valid;
  s1a_pkg::char_t       out_char;
  logic                 out_unknown;

  logic                 accept;
  logic [s1a_pkg::ByteW-1:0] b;
  logic [6:0]           low7;
  logic                 is_break;
  logic                 is_make;
  logic                 col;
  s1a_pkg::key_pair_t   pair;
  s1a_pkg::char_t       ch;
  logic                 unknown;

  assign scan.ready = !out_valid || result.ready;
  assign accept     = scan.valid && scan.ready;
  assign b          = scan.scan_byte;
  assign low7       = b[6:0];

  always_comb begin
    prefix_seen_next  = prefix_seen;
    ctrl_held_next    = ctrl_held;
    shift_held_next   = shift_held;
    alt_held_next     = alt_held;
    caps_lock_on_next = caps_lock_on;
    ch                = '0;
    unknown           = 1'b0;
    is_break          = b[7];
    is_make           = prefix_seen ? ((b == s1a_pkg::CodeAlt) || (b == s1a_pkg::CodeCtrl))
                                    : ((b != '0) && (b <= s1a_pkg::CodeLastKey));
    col               = (!prefix_seen && s1a_pkg::is_symbol_key(b)) ? shift_held
                                                                    : (shift_held ^ caps_lock_on);
    pair              = s1a_pkg::key_lookup(b[s1a_pkg::IdxW-1:0]);
    if (b == s1a_pkg::CodePrefix) begin
      prefix_seen_next = 1'b1;
    end else begin
      prefix_seen_next = 1'b0;
      if (is_break) begin
        if (low7 == s1a_pkg::CodeCtrl[6:0]) ctrl_held_next = 1'b0;
        if (!prefix_seen && ((low7 == s1a_pkg::CodeLShift[6:0]) ||
                             (low7 == s1a_pkg::CodeRShift[6:0]))) shift_held_next = 1'b0;
        if (low7 == s1a_pkg::CodeAlt[6:0]) alt_held_next = 1'b0;
      end else if (is_make) begin
        ch = col ? pair.upper : pair.lower;
        if (ch == '0) begin
          priority if (b == s1a_pkg::CodeCtrl) begin
            ctrl_held_next = 1'b1;
          end else if ((b == s1a_pkg::CodeLShift) || (b == s1a_pkg::CodeRShift)) begin
            shift_held_next = 1'b1;
          end else if (b == s1a_pkg::CodeAlt) begin
            alt_held_next = 1'b1;
          end else if (b == s1a_pkg::CodeCaps) begin
            caps_lock_on_next = !caps_lock_on;
          end
        end
      end else begin
        unknown = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      prefix_seen  <= 1'b0;
      ctrl_held    <= 1'b0;
      shift_held   <= 1'b0;
      alt_held     <= 1'b0;
      caps_lock_on <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (accept) begin
        prefix_seen  <= prefix_seen_next;
        ctrl_held    <= ctrl_held_next;
        shift_held   <= shift_held_next;
        alt_held     <= alt_held_next;
        caps_lock_on <= caps_lock_on_next;
        out_valid    <= 1'b1;
      end else if (result.ready) begin
        out_valid    <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_char_valid <= (ch != '0);
      out_char       <= ch;
      out_unknown    <= unknown;
    end
  end

  assign result.valid       = out_valid;
  assign result.char_valid  = out_char_valid;
  assign result.ascii_char  = out_char;
  assign result.unknown_key = out_unknown;
  assign result.ctrl_down   = ctrl_held;
  assign result.shift_down  = shift_held;
  assign result.alt_down    = alt_held;
  assign result.caps_on     = caps_lock_on;

`ifndef NO_ASSERTIONS
  a_char_flag: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> (result.char_valid == (result.ascii_char != '0)))
    else $error("char_valid disagrees with ascii_char");

  a_char_xor_unknown: assert property (@(posedge clk) disable iff (rst)
    result.valid |-> !(result.char_valid && result.unknown_key))
    else $error("character and unknown flag both set");

  a_prefix_silent: assert property (@(posedge clk) disable iff (rst)
    (accept && (scan.scan_byte == s1a_pkg::CodePrefix)) |=>
      (result.valid && !result.char_valid && !result.unknown_key && prefix_seen))
    else $error("prefix byte produced output or lost prefix flag");

  a_caps_hold: assert property (@(posedge clk) disable iff (rst)
    !accept |=> $stable(caps_lock_on))
    else $error("caps lock changed without a request");
`endif

endmodule

@@ tb/sv/scancode_set1_to_ascii_tb.sv @@
`timescale 1ns / 1ps

module scancode_set1_to_ascii_tb;

  localparam int unsigned CycleLimit = 400000;
  localparam int unsigned RandomItems = 1600;
  localparam int unsigned DrainCycles = 4;

  localparam logic [s1a_pkg::ByteW-1:0] BreakBit = 8'h80;
  localparam logic [15:0] ExtCtrl = {s1a_pkg::CodePrefix, s1a_pkg::CodeCtrl};
  localparam logic [15:0] ExtAlt  = {s1a_pkg::CodePrefix, s1a_pkg::CodeAlt};

  typedef struct packed {
    logic                      char_valid;
    logic [s1a_pkg::CharW-1:0] ascii_char;
    logic                      unknown_key;
    logic                      ctrl_down;
    logic                      shift_down;
    logic                      alt_down;
    logic                      caps_on;
  } key_result_t;

  typedef struct {
    logic [s1a_pkg::ByteW-1:0] scan_byte;
    bit                        typed;
    key_result_t               want;
  } key_request_t;

  localparam key_result_t NoneOut    = '0;
  localparam key_result_t UnknownOut = '{char_valid: 1'b0, ascii_char: '0, unknown_key: 1'b1,
                                         ctrl_down: 1'b0, shift_down: 1'b0, alt_down: 1'b0,
                                         caps_on: 1'b0};
  localparam key_result_t EscOut     = '{char_valid: 1'b1, ascii_char: 7'h1B, unknown_key: 1'b0,
                                         ctrl_down: 1'b0, shift_down: 1'b0, alt_down: 1'b0,
                                         caps_on: 1'b0};

  logic clk = 1'b0;
  logic rst;

  s1a_in_if  scan ();
  s1a_out_if result ();

  scancode_set1_to_ascii dut (
    .clk    (clk),
    .rst    (rst),
    .scan   (scan),
    .result (result)
  );

  always #1 clk = ~clk;

  logic prefix_seen = 1'b0;
  logic ctrl_held   = 1'b0;
  logic shift_held  = 1'b0;
  logic alt_held    = 1'b0;
  logic caps_held   = 1'b0;

  key_request_t request_q[$];
  key_result_t  expected_q[$];
  int unsigned  errors = 0;
  int unsigned  cycles = 0;
  int unsigned  send_idle_pct;
  int unsigned  recv_idle_pct;

  key_request_t intro_rows[] = '{
    '{8'h00, 1'b1, UnknownOut},
    '{8'hFF, 1'b1, NoneOut},
    '{8'h01, 1'b1, EscOut},
    '{8'h3B, 1'b1, UnknownOut},
    '{8'hE0, 1'b1, NoneOut},
    '{8'hE0, 1'b1, NoneOut},
    '{8'h00, 1'b1, UnknownOut},
    '{8'h2A, 1'b0, NoneOut},
    '{8'h10, 1'b0, NoneOut},
    '{8'h02, 1'b0, NoneOut},
    '{8'h3A, 1'b0, NoneOut},
    '{8'h10, 1'b0, NoneOut},
    '{8'hE0, 1'b0, NoneOut},
    '{8'hAA, 1'b0, NoneOut},
    '{8'hAA, 1'b0, NoneOut},
    '{8'h1E, 1'b0, NoneOut},
    '{8'hE0, 1'b0, NoneOut},
    '{8'h1D, 1'b0, NoneOut},
    '{8'hE0, 1'b0, NoneOut},
    '{8'h38, 1'b0, NoneOut},
    '{8'hE0, 1'b0, NoneOut},
    '{8'h9D, 1'b0, NoneOut},
    '{8'hB8, 1'b0, NoneOut},
    '{8'hE1, 1'b0, NoneOut},
    '{8'hE0, 1'b0, NoneOut},
    '{8'h7F, 1'b0, NoneOut},
    '{8'h39, 1'b0, NoneOut}
  };

  function automatic logic [15:0] key_chars(input logic [7:0] idx);
    logic [15:0] pair;
    case (idx)
      8'h01: pair = {8'h1B, 8'h1B};
      8'h02: pair = {"1", "!"};
      8'h03: pair = {"2", "@"};
      8'h04: pair = {"3", "#"};
      8'h05: pair = {"4", "$"};
      8'h06: pair = {"5", "%"};
      8'h07: pair = {"6", "^"};
      8'h08: pair = {"7", "&"};
      8'h09: pair = {"8", "*"};
      8'h0A: pair = {"9", "("};
      8'h0B: pair = {"0", ")"};
      8'h0C: pair = {"-", "_"};
      8'h0D: pair = {"=", "+"};
      8'h0E: pair = {8'h08, 8'h08};
      8'h0F: pair = {8'h09, 8'h09};
      8'h10: pair = {"q", "Q"};
      8'h11: pair = {"w", "W"};
      8'h12: pair = {"e", "E"};
      8'h13: pair = {"r", "R"};
      8'h14: pair = {"t", "T"};
      8'h15: pair = {"y", "Y"};
      8'h16: pair = {"u", "U"};
      8'h17: pair = {"i", "I"};
      8'h18: pair = {"o", "O"};
      8'h19: pair = {"p", "P"};
      8'h1A: pair = {"[", "{"};
      8'h1B: pair = {"]", "}"};
      8'h1C: pair = {8'h0D, 8'h0D};
      8'h1E: pair = {"a", "A"};
      8'h1F: pair = {"s", "S"};
      8'h20: pair = {"d", "D"};
      8'h21: pair = {"f", "F"};
      8'h22: pair = {"g", "G"};
      8'h23: pair = {"h", "H"};
      8'h24: pair = {"j", "J"};
      8'h25: pair = {"k", "K"};
      8'h26: pair = {"l", "L"};
      8'h27: pair = {";", ":"};
      8'h28: pair = {"'", "\""};
      8'h29: pair = {8'h60, "~"};
      8'h2B: pair = {"\\", "|"};
      8'h2C: pair = {"z", "Z"};
      8'h2D: pair = {"x", "X"};
      8'h2E: pair = {"c", "C"};
      8'h2F: pair = {"v", "V"};
      8'h30: pair = {"b", "B"};
      8'h31: pair = {"n", "N"};
      8'h32: pair = {"m", "M"};
      8'h33: pair = {",", "<"};
      8'h34: pair = {".", ">"};
      8'h35: pair = {"/", "?"};
      8'h37: pair = {"*", "*"};
      8'h39: pair = {" ", " "};
      default: pair = 16'h0000;
    endcase
    return pair;
  endfunction

  function automatic logic shift_only_key(input logic [15:0] code);
    return (code < 16'h0E) || (code == 16'h1A) || (code == 16'h1B) || (code == 16'h2B) ||
           ((code > 16'h26) && (code < 16'h2A)) || ((code > 16'h32) && (code < 16'h36));
  endfunction

  function automatic key_result_t decode_scan(input logic [s1a_pkg::ByteW-1:0] b);
    logic [15:0] code;
    logic [15:0] base;
    logic [15:0] pair;
    logic [7:0]  idx;
    logic [7:0]  ch;
    logic        upper;
    key_result_t r;
    r = '0;
    ch = 8'h00;
    if (b == s1a_pkg::CodePrefix) begin
      prefix_seen = 1'b1;
    end else begin
      code = {8'h00, b};
      if (prefix_seen) begin
        code[15:8] = s1a_pkg::CodePrefix;
        prefix_seen = 1'b0;
      end
      if ((code[7:0] & BreakBit) != 0) begin
        base = code & ~{8'h00, BreakBit};
        if (base == {8'h00, s1a_pkg::CodeCtrl} || base == ExtCtrl) ctrl_held = 1'b0;
        if (base == {8'h00, s1a_pkg::CodeLShift} ||
            base == {8'h00, s1a_pkg::CodeRShift}) shift_held = 1'b0;
        if (base == {8'h00, s1a_pkg::CodeAlt} || base == ExtAlt) alt_held = 1'b0;
      end else if ((code > 0 && code <= {8'h00, s1a_pkg::CodeLastKey}) || code == ExtAlt ||
                   code == ExtCtrl) begin
        idx = code[7:0];
        upper = shift_only_key(code) ? shift_held : (shift_held ^ caps_held);
        pair = key_chars(idx);
        ch = upper ? pair[7:0] : pair[15:8];
        if (ch == 8'h00) begin
          if (idx == s1a_pkg::CodeCtrl) ctrl_held = 1'b1;
          else if (idx == s1a_pkg::CodeLShift || idx == s1a_pkg::CodeRShift) shift_held = 1'b1;
          else if (idx == s1a_pkg::CodeAlt) alt_held = 1'b1;
          else if (idx == s1a_pkg::CodeCaps) caps_held = ~caps_held;
        end
      end else begin
        r.unknown_key = 1'b1;
      end
    end
    r.char_valid = (ch != 8'h00);
    r.ascii_char = ch[s1a_pkg::CharW-1:0];
    r.ctrl_down  = ctrl_held;
    r.shift_down = shift_held;
    r.alt_down   = alt_held;
    r.caps_on    = caps_held;
    return r;
  endfunction

  task automatic send_byte(input logic [s1a_pkg::ByteW-1:0] b, input bit typed,
                           input key_result_t want);
    while ($urandom_range(99) < send_idle_pct) begin
      scan.valid <= 1'b0;
      @(posedge clk);
    end
    scan.valid     <= 1'b1;
    scan.scan_byte <= b;
    request_q.push_back('{b, typed, want});
    do @(posedge clk); while (!scan.ready);
  endtask

  always @(posedge clk) begin
    result.ready <= ($urandom_range(99) >= recv_idle_pct);
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= CycleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  always @(posedge clk) begin
    key_request_t req;
    key_result_t  model_out;
    key_result_t  want;
    if (!rst) begin
      if (scan.valid && scan.ready) begin
        req = request_q.pop_front();
        model_out = decode_scan(req.scan_byte);
        expected_q.push_back(req.typed ? req.want : model_out);
      end
      if (result.valid && result.ready) begin
        if (expected_q.size() == 0) begin
          $error("result arrived with no request pending");
          errors++;
        end else begin
          want = expected_q.pop_front();
          if (result.char_valid !== want.char_valid) begin
            $error("char_valid expected %0h got %0h", want.char_valid, result.char_valid);
            errors++;
          end
          if (result.ascii_char !== want.ascii_char) begin
            $error("ascii_char expected %0h got %0h", want.ascii_char, result.ascii_char);
            errors++;
          end
          if (result.unknown_key !== want.unknown_key) begin
            $error("unknown_key expected %0h got %0h", want.unknown_key, result.unknown_key);
            errors++;
          end
          if (result.ctrl_down !== want.ctrl_down) begin
            $error("ctrl_down expected %0h got %0h", want.ctrl_down, result.ctrl_down);
            errors++;
          end
          if (result.shift_down !== want.shift_down) begin
            $error("shift_down expected %0h got %0h", want.shift_down, result.shift_down);
            errors++;
          end
          if (result.alt_down !== want.alt_down) begin
            $error("alt_down expected %0h got %0h", want.alt_down, result.alt_down);
            errors++;
          end
          if (result.caps_on !== want.caps_on) begin
            $error("caps_on expected %0h got %0h", want.caps_on, result.caps_on);
            errors++;
          end
        end
      end
    end
  end

  initial begin
    int unsigned sent;
    int unsigned pick;
    logic [s1a_pkg::ByteW-1:0] ext;
    rst            = 1'b1;
    scan.valid     = 1'b0;
    scan.scan_byte = '0;
    send_idle_pct  = 31;
    recv_idle_pct  = 77;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (intro_rows[i]) send_byte(intro_rows[i].scan_byte, intro_rows[i].typed,
                                      intro_rows[i].want);

    sent = 0;
    for (int phase = 0; phase < 3; phase++) begin
      send_idle_pct = (phase == 0) ? 31 : (phase == 1) ? 77 : 0;
      recv_idle_pct = (phase == 0) ? 77 : (phase == 1) ? 31 : 0;
      while (sent < RandomItems * (phase + 1) / 3) begin
        pick = $urandom_range(99);
        if (pick < 55) begin
          send_byte(8'($urandom_range(s1a_pkg::CodeLastKey, 1)), 1'b0, NoneOut);
          sent++;
        end else if (pick < 75) begin
          send_byte(8'($urandom_range(s1a_pkg::CodeLastKey, 1)) | BreakBit, 1'b0, NoneOut);
          sent++;
        end else if (pick < 88) begin
          case ($urandom_range(6))
            0: ext = s1a_pkg::CodeCtrl;
            1: ext = s1a_pkg::CodeAlt;
            2: ext = s1a_pkg::CodeCtrl | BreakBit;
            3: ext = s1a_pkg::CodeAlt | BreakBit;
            4: ext = s1a_pkg::CodeLShift | BreakBit;
            5: ext = s1a_pkg::CodeRShift | BreakBit;
            default: ext = 8'($urandom_range(255));
          endcase
          send_byte(s1a_pkg::CodePrefix, 1'b0, NoneOut);
          send_byte(ext, 1'b0, NoneOut);
          sent += 2;
        end else begin
          send_byte(8'($urandom_range(255)), 1'b0, NoneOut);
          sent++;
        end
      end
    end
    scan.valid <= 1'b0;

    while (expected_q.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);
    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule

@@ sim.f @@
sv/s1a_pkg.sv
sv/s1a_if.sv
sv/scancode_set1_to_ascii.sv
tb/sv/scancode_set1_to_ascii_tb.sv
